>>> design/hktm_pkg.sv
// shared types and constants for the held key table and key matrix
`default_nettype none
package hktm_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W       = 16;
	localparam int POS_W       = 6;
	localparam int MATRIX_W    = 64;
	localparam int COUNT_OUT_W = 7;
	localparam logic [POS_W-1:0] SHIFT_POS = 6'd56;

	typedef enum logic [1:0] {
		FUNC_PRESS   = 2'd0,
		FUNC_RELEASE = 2'd1,
		FUNC_CLEAR   = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DONE
	} state_t;

	// matrix code of one press: valid, shifted, position
	typedef struct packed {
		logic             valid;
		logic             shift;
		logic [POS_W-1:0] pos;
	} code_t;

	// one held-key table entry
	typedef struct packed {
		logic [KEY_W-1:0] id;
		code_t            code;
	} entry_t;

	// search token passed from cell to cell
	typedef struct packed {
		logic  tok;
		logic  found;
		code_t code;
	} tok_t;

	// per-cell control from the top level
	typedef struct packed {
		logic occ;
		logic app;
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> design/held_key_table_matrix_top.sv
// top level: held key table as a chain of cells plus the 8x8 key matrix
//
// channel   dir  width  handshake              contents
// s_*       in   32     s_tvalid & s_tready    one key event
// m_*       out  72     m_tvalid & m_tready    matrix, held count, full flag
//
// press and release step through: accept, then the search token
// walks the cell chain (one cell per cycle), then the token leaves the last
// cell, then the block updates and loads the result
// clear and unused codes skip the walk; a waiting result holds the block in its
// final step until taken, and the next event is accepted once the result is loaded
// arst_n clears the held count, the matrix and all handshake state; table
// entries are not cleared, only entries below the held count are ever looked at
`default_nettype none
module held_key_table_matrix_top
	import hktm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// [1:0] func, [17:2] host_key, [18] code_valid, [24:19] matrix_pos,
	// [25] with_shift, [31:26] zero
	input  wire logic [31:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [63:0] matrix_bits, [70:64] held_count, [71] table_full
	output logic [71:0]      m_tdata
);

	// control
	state_t state_q, state_d;
	logic   start_q;
	logic   load_out;
	logic   accept;
	logic   walk_func;

	// current item
	func_t            in_func;
	func_t            func_q;
	logic [KEY_W-1:0] key_q;
	code_t            code_item_q;

	// architectural state
	logic [CNT_W-1:0]    count_q, count_d;
	logic [MATRIX_W-1:0] matrix_q, matrix_d;
	logic                dropped;
	logic                append;

	// result register
	logic                   m_tvalid_q;
	logic [MATRIX_W-1:0]    out_matrix_q;
	logic [COUNT_OUT_W-1:0] out_count_q;
	logic                   out_full_q;

	// cell chain wiring
	tok_t      tok_w [TABLE_DEPTH+1];
	entry_t    entry_w [TABLE_DEPTH];
	cell_ctl_t ctl_w [TABLE_DEPTH];
	entry_t    app_entry;
	tok_t      walk_res;

	assign in_func   = func_t'(s_tdata[1:0]);
	assign walk_func = (in_func == FUNC_PRESS) || (in_func == FUNC_RELEASE);
	assign accept    = s_tvalid && s_tready;
	assign walk_res  = tok_w[TABLE_DEPTH];

	// token enters the first cell in the cycle after accept, with nothing found yet
	assign tok_w[0].tok   = start_q;
	assign tok_w[0].found = 1'b0;
	assign tok_w[0].code  = code_item_q;

	assign app_entry.id   = key_q;
	assign app_entry.code = code_item_q;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			entry_t right_e;
			if (gi == TABLE_DEPTH - 1) begin : g_last
				assign right_e = entry_w[gi];
			end else begin : g_mid
				assign right_e = entry_w[gi+1];
			end
			// occupied below the held count; a new key lands at the held count
			assign ctl_w[gi].occ = CNT_W'(gi) < count_q;
			assign ctl_w[gi].app = append && (CNT_W'(gi) == count_q);

			hktm_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.tok_in     (tok_w[gi]),
				.tok_out    (tok_w[gi+1]),
				.right      (right_e),
				.entry      (entry_w[gi]),
				.key        (key_q),
				.release_op (func_q == FUNC_RELEASE),
				.ctl        (ctl_w[gi]),
				.app_entry  (app_entry)
			);
		end
	endgenerate

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= accept && walk_func;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = walk_func ? ST_WALK : ST_DONE;
				end
			end
			ST_WALK: begin
				// token has left the last cell
				if (walk_res.tok) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// item capture
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q            <= in_func;
			key_q             <= s_tdata[17:2];
			code_item_q.valid <= s_tdata[18];
			code_item_q.pos   <= s_tdata[24:19];
			code_item_q.shift <= s_tdata[25];
		end
	end

	// table count and matrix update, applied in the final step
	always_comb begin
		count_d  = count_q;
		matrix_d = matrix_q;
		dropped  = 1'b0;
		append   = 1'b0;
		case (func_q)
			FUNC_PRESS: begin
				if (!walk_res.found) begin
					if (count_q < CNT_W'(TABLE_DEPTH)) begin
						append  = load_out;
						count_d = count_q + CNT_W'(1);
					end else begin
						dropped = 1'b1;
					end
				end
				if (code_item_q.valid) begin
					matrix_d = matrix_d | (MATRIX_W'(1) << code_item_q.pos);
					if (code_item_q.shift) begin
						matrix_d = matrix_d | (MATRIX_W'(1) << SHIFT_POS);
					end else if (code_item_q.pos != SHIFT_POS) begin
						// the shift key itself never clears its own bit
						matrix_d = matrix_d & ~(MATRIX_W'(1) << SHIFT_POS);
					end
				end
			end
			FUNC_RELEASE: begin
				if (walk_res.found) begin
					count_d = count_q - CNT_W'(1);
					if (walk_res.code.valid) begin
						matrix_d = matrix_d & ~(MATRIX_W'(1) << walk_res.code.pos);
						if (walk_res.code.shift) begin
							matrix_d = matrix_d & ~(MATRIX_W'(1) << SHIFT_POS);
						end
					end
				end
			end
			FUNC_CLEAR: begin
				matrix_d = '0;
			end
			default: begin
				// unused code leaves everything as is
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			matrix_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load_out) begin
				count_q    <= count_d;
				matrix_q   <= matrix_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			out_matrix_q <= matrix_d;
			out_count_q  <= COUNT_OUT_W'(count_d);
			out_full_q   <= dropped;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {out_full_q, out_count_q, out_matrix_q};

endmodule
`default_nettype wire

>>> design/hktm_cell.sv
// one held-key table cell: stores an entry, checks the passing token, shifts on removal
`default_nettype none
module hktm_cell
	import hktm_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tok_t             tok_in,
	output tok_t                  tok_out,
	input  wire entry_t           right,
	output entry_t                entry,
	input  wire logic [KEY_W-1:0] key,
	input  wire logic             release_op,
	input  wire cell_ctl_t        ctl,
	input  wire entry_t           app_entry
);

	entry_t entry_q;
	logic   tok_q;
	logic   found_q;
	code_t  code_q;
	logic   match;

	// first listed entry with this key
	assign match = ctl.occ && !tok_in.found && (entry_q.id == key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			found_q <= 1'b0;
		end else begin
			tok_q <= tok_in.tok;
			if (tok_in.tok) begin
				found_q <= tok_in.found || match;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.tok) begin
			code_q <= match ? entry_q.code : tok_in.code;
		end
	end

	// removal closes the gap: cells from the match onward take the right neighbor
	always_ff @(posedge clk) begin
		if (ctl.app) begin
			entry_q <= app_entry;
		end else if (tok_in.tok && release_op && (tok_in.found || match)) begin
			entry_q <= right;
		end
	end

	assign tok_out.tok   = tok_q;
	assign tok_out.found = found_q;
	assign tok_out.code  = code_q;
	assign entry         = entry_q;

endmodule
`default_nettype wire

>>> dv/held_key_table_matrix_checker.sv
// checker: predicts the result of each key event and compares result channel transfers
`timescale 1ns / 1ps
module held_key_table_matrix_checker
	import hktm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [31:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [71:0] m_tdata,
	output int               mismatches,
	output int               outstanding
);

	// result layout, lowest field in the lowest bits
	typedef struct packed {
		logic                   full;
		logic [COUNT_OUT_W-1:0] count;
		logic [MATRIX_W-1:0]    matrix;
	} matrix_report_t;

	entry_t              held_list [TABLE_DEPTH];
	int                  held_n;
	logic [MATRIX_W-1:0] matrix_q;
	matrix_report_t      pending_reports [$];
	matrix_report_t      want;
	matrix_report_t      got;

	function automatic int find_held(input logic [KEY_W-1:0] key);
		int i;
		for (i = 0; i < held_n; i++)
			if (held_list[i].id == key)
				return i;
		return -1;
	endfunction

	function automatic matrix_report_t predict_event(input logic [31:0] ev);
		func_t            fn;
		logic [KEY_W-1:0] key;
		code_t            c;
		code_t            hit;
		int               idx;
		int               i;
		logic             dropped;
		matrix_report_t   rep;
		fn      = func_t'(ev[1:0]);
		key     = ev[17:2];
		c.valid = ev[18];
		c.pos   = ev[24:19];
		c.shift = ev[25];
		dropped = 1'b0;
		case (fn)
			FUNC_PRESS: begin
				idx = find_held(key);
				if (idx < 0) begin
					if (held_n < TABLE_DEPTH) begin
						held_list[held_n].id   = key;
						held_list[held_n].code = c;
						held_n++;
					end else begin
						dropped = 1'b1;
					end
				end
				// matrix follows this press's code even when the key was listed or dropped
				if (c.valid) begin
					matrix_q[c.pos] = 1'b1;
					if (c.shift)
						matrix_q[SHIFT_POS] = 1'b1;
					else if (c.pos != SHIFT_POS)
						matrix_q[SHIFT_POS] = 1'b0;
				end
			end
			FUNC_RELEASE: begin
				idx = find_held(key);
				if (idx >= 0) begin
					hit = held_list[idx].code;
					for (i = idx + 1; i < held_n; i++)
						held_list[i-1] = held_list[i];
					held_n--;
					if (hit.valid) begin
						matrix_q[hit.pos] = 1'b0;
						if (hit.shift)
							matrix_q[SHIFT_POS] = 1'b0;
					end
				end
			end
			FUNC_CLEAR: matrix_q = '0;
			default: ;
		endcase
		rep.matrix = matrix_q;
		rep.count  = COUNT_OUT_W'(held_n);
		rep.full   = dropped;
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_n   = 0;
			matrix_q = '0;
			pending_reports.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			// a result never leaves in the cycle its event is accepted, so check before predicting
			if (m_tvalid && m_tready) begin
				got = matrix_report_t'(m_tdata);
				if (pending_reports.size() == 0) begin
					$error("result transfer with no event outstanding: %h", m_tdata);
					mismatches++;
				end else begin
					want = pending_reports.pop_front();
					if (got.matrix !== want.matrix) begin
						$error("matrix_bits: expected %h, actual %h", want.matrix, got.matrix);
						mismatches++;
					end
					if (got.count !== want.count) begin
						$error("held_count: expected %0d, actual %0d", want.count, got.count);
						mismatches++;
					end
					if (got.full !== want.full) begin
						$error("table_full: expected %b, actual %b", want.full, got.full);
						mismatches++;
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_reports.push_back(predict_event(s_tdata));
			outstanding = pending_reports.size();
		end
	end

endmodule

>>> dv/held_key_table_matrix_top_tb.sv
// testbench top: key event stimulus, result channel back-pressure and the verdict
`timescale 1ns / 1ps
module held_key_table_matrix_top_tb;
	import hktm_pkg::*;

	localparam int EVENT_TARGET = 1600;
	// covers a press or release, plus the longest stall and gap
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 100;
	// func code the block does not use
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	// [1:0] func, [17:2] host_key, [18] code_valid, [24:19] matrix_pos,
	// [25] with_shift, [31:26] zero
	logic [31:0] s_tdata  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [63:0] matrix_bits, [70:64] held_count, [71] table_full
	logic [71:0] m_tdata;

	int mismatches;
	int outstanding;
	int idle_cycles = 0;
	int burst_left  = 0;
	int ready_left  = 0;
	int events_sent = 0;

	// keys pressed and not yet released, used to aim releases and repeat presses at listed keys and to size fill runs
	logic [KEY_W-1:0] tracked_keys [$];

	// 20 ns clock
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	held_key_table_matrix_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	held_key_table_matrix_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic logic [31:0] key_event(input logic [1:0] fn, input logic [KEY_W-1:0] key,
			input logic valid, input logic [POS_W-1:0] pos, input logic shift);
		return {6'b0, shift, pos, valid, key, fn};
	endfunction

	// mostly fresh keys, sometimes one already held to hit the listed-key path
	function automatic logic [KEY_W-1:0] press_key();
		if (tracked_keys.size() > 0 && $urandom_range(0, 99) < 30)
			return tracked_keys[$urandom_range(0, tracked_keys.size() - 1)];
		return KEY_W'($urandom());
	endfunction

	// mostly keys that are held, the rest unlisted
	function automatic logic [KEY_W-1:0] release_key();
		if (tracked_keys.size() > 0 && $urandom_range(0, 99) < 85)
			return tracked_keys[$urandom_range(0, tracked_keys.size() - 1)];
		return KEY_W'($urandom());
	endfunction

	// the shift position gets extra weight
	function automatic logic [POS_W-1:0] pick_pos();
		if ($urandom_range(0, 9) == 0)
			return SHIFT_POS;
		return POS_W'($urandom_range(0, 63));
	endfunction

	// one transfer on the event channel, then either stay in the burst or open a gap
	task automatic send_event(input logic [31:0] ev);
		int               idx;
		logic [KEY_W-1:0] key;
		key = ev[17:2];
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= ev;
		do @(posedge clk); while (!s_tready);
		if (ev[1:0] != FUNC_UNUSED)
			events_sent++;
		idx = -1;
		foreach (tracked_keys[i])
			if (idx < 0 && tracked_keys[i] == key)
				idx = i;
		if (ev[1:0] == FUNC_PRESS && idx < 0)
			tracked_keys.push_back(key);
		else if (ev[1:0] == FUNC_RELEASE && idx >= 0)
			tracked_keys.delete(idx);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom();
			repeat ($urandom_range(0, 20)) @(negedge clk);
			// long bursts now and then give runs with no sender gaps
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
			                                         : $urandom_range(0, 8);
		end
	endtask

	task automatic press_random();
		send_event(key_event(FUNC_PRESS, press_key(), $urandom_range(0, 9) != 0, pick_pos(),
			1'($urandom_range(0, 1))));
	endtask

	// result channel back-pressure: stall stretches and ready stretches of random length
	always @(negedge clk) begin
		if (ready_left == 0) begin
			if ($urandom_range(0, 2) == 0) begin
				m_tready   <= 1'b0;
				ready_left = $urandom_range(1, 12);
			end else begin
				m_tready   <= 1'b1;
				ready_left = $urandom_range(1, 60);
			end
		end else begin
			ready_left--;
		end
	end

	// watchdog: cycles without any transfer on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("held_key_table_matrix_top verification failed");
				$finish;
			end
		end
	end

	initial begin
		int mode;
		int n;
		int pick;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, forced shift and its removal
		send_event(key_event(FUNC_PRESS, 16'hFFFF, 1'b1, 6'd63, 1'b1));
		send_event(key_event(FUNC_PRESS, 16'h0000, 1'b1, 6'd0, 1'b0));
		// shift key itself without forced shift keeps its own bit
		send_event(key_event(FUNC_PRESS, 16'h1234, 1'b1, SHIFT_POS, 1'b0));
		// code of none is listed but leaves the matrix alone
		send_event(key_event(FUNC_PRESS, 16'hA5A5, 1'b0, 6'd21, 1'b1));
		// key already listed: stored code kept, matrix takes the new code
		send_event(key_event(FUNC_PRESS, 16'h0000, 1'b1, 6'd9, 1'b1));
		send_event(key_event(FUNC_RELEASE, 16'h0000, 1'b0, 6'd0, 1'b0));
		send_event(key_event(FUNC_RELEASE, 16'hA5A5, 1'b1, 6'd63, 1'b1));
		// release of an unlisted key
		send_event(key_event(FUNC_RELEASE, 16'hBEEF, 1'b1, 6'd42, 1'b0));
		// unused func with every field bit high
		send_event(key_event(FUNC_UNUSED, 16'hFFFF, 1'b1, 6'd63, 1'b1));
		send_event(key_event(FUNC_CLEAR, 16'h5555, 1'b1, 6'd42, 1'b1));
		send_event(key_event(FUNC_RELEASE, 16'hFFFF, 1'b0, 6'd0, 1'b0));
		send_event(key_event(FUNC_RELEASE, 16'h1234, 1'b0, 6'd0, 1'b0));
		send_event(key_event(FUNC_PRESS, 16'h5A5A, 1'b1, SHIFT_POS, 1'b1));
		send_event(key_event(FUNC_PRESS, 16'h00FF, 1'b1, 6'd7, 1'b0));
		send_event(key_event(FUNC_RELEASE, 16'h5A5A, 1'b0, 6'd0, 1'b0));
		send_event(key_event(FUNC_RELEASE, 16'h00FF, 1'b0, 6'd0, 1'b0));

		// random: mixed traffic, fills past the table depth, and drains
		while (events_sent < EVENT_TARGET) begin
			mode = $urandom_range(0, 9);
			if (mode < 6) begin
				n = $urandom_range(5, 30);
				repeat (n) begin
					pick = $urandom_range(0, 99);
					if (pick < 45)
						press_random();
					else if (pick < 85)
						send_event(key_event(FUNC_RELEASE, release_key(),
							1'($urandom_range(0, 1)), POS_W'($urandom()),
							1'($urandom_range(0, 1))));
					else if (pick < 93)
						send_event(key_event(FUNC_CLEAR, KEY_W'($urandom()),
							1'($urandom_range(0, 1)), POS_W'($urandom()),
							1'($urandom_range(0, 1))));
					else
						send_event(key_event(FUNC_UNUSED, KEY_W'($urandom()),
							1'($urandom_range(0, 1)), POS_W'($urandom()),
							1'($urandom_range(0, 1))));
				end
			end else if (mode < 8) begin
				// press fresh keys until the table overflows
				n = TABLE_DEPTH + 6 - tracked_keys.size();
				if (n < 5)
					n = 5;
				repeat (n)
					send_event(key_event(FUNC_PRESS, KEY_W'($urandom()), $urandom_range(0, 9) != 0,
						pick_pos(), 1'($urandom_range(0, 1))));
			end else begin
				// release held keys in random order, with a stray unlisted one now and then
				n = tracked_keys.size() + 1;
				repeat (n) begin
					if (tracked_keys.size() == 0 || $urandom_range(0, 9) == 0)
						send_event(key_event(FUNC_RELEASE, KEY_W'($urandom()), 1'b1,
							POS_W'($urandom()), 1'b1));
					else
						send_event(key_event(FUNC_RELEASE,
							tracked_keys[$urandom_range(0, tracked_keys.size() - 1)],
							1'($urandom_range(0, 1)), POS_W'($urandom()),
							1'($urandom_range(0, 1))));
				end
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		// catch any stray result after the last expected one
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("held_key_table_matrix_top verification clean");
		else
			$display("held_key_table_matrix_top verification failed");
		$finish;
	end

endmodule

>>> sim.f
design/hktm_pkg.sv
design/hktm_cell.sv
design/held_key_table_matrix_top.sv
dv/held_key_table_matrix_checker.sv
dv/held_key_table_matrix_top_tb.sv
